// File: sv/crg_pkg.sv
`timescale 1ns / 1ps

package crg_pkg;

    localparam int FRAC_BITS      = 12;
    localparam int MAX_RESOLUTION = 4096;

    localparam int COMP_W     = 20;
    localparam int VEC_W      = 3 * COMP_W;
    localparam int EXT_W      = 2 * COMP_W;
    localparam int OUT_W      = 24;
    localparam int PIX_W      = 12;
    localparam int RES_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VEC_W;

    localparam int DIM_W      = $clog2(MAX_RESOLUTION + 1);
    localparam int T_W        = PIX_W + 2;
    localparam int PROD_W     = COMP_W + T_W;
    localparam int MAG_W      = PROD_W - 1;
    localparam int NUM_W      = MAG_W + 1;
    localparam int DEN_W      = DIM_W + 1;
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_BPS - 1) / DIV_BPS;
    localparam int NUM_PAD_W  = DIV_STAGES * DIV_BPS;
    localparam int OFS_W      = MAG_W + 1;
    localparam int PROD2_W    = OFS_W + COMP_W;
    localparam int ACC_W      = PROD2_W + 2;

    localparam logic [RES_W-1:0] WIDTH_RESET  = RES_W'(640);
    localparam logic [RES_W-1:0] HEIGHT_RESET = RES_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_EXTENTS = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_U = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_V = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_EYE     = CFG_IDX_W'(7);

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic             ortho;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        comp_t            ext_r;
        comp_t            ext_t;
        logic [VEC_W-1:0] basis_u;
        logic [VEC_W-1:0] basis_v;
        logic [VEC_W-1:0] forward;
        logic [VEC_W-1:0] eye;
    } cam_cfg_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_in_t;

    // Component 0 is x in the top bits, component 2 is z in the low bits.
    function automatic comp_t vec_comp(input logic [VEC_W-1:0] v, input int i);
        return comp_t'(v[COMP_W * (2 - i) +: COMP_W]);
    endfunction

endpackage

// File: sv/crg_config.sv
`timescale 1ns / 1ps

module crg_config (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [crg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output crg_pkg::cam_cfg_t                  cfg
);

    logic                          mode_reg;
    logic [crg_pkg::RES_W-1:0]     width_reg;
    logic [crg_pkg::RES_W-1:0]     height_reg;
    logic [crg_pkg::EXT_W-1:0]     extents_reg;
    logic [crg_pkg::VEC_W-1:0]     basis_u_reg;
    logic [crg_pkg::VEC_W-1:0]     basis_v_reg;
    logic [crg_pkg::VEC_W-1:0]     forward_reg;
    logic [crg_pkg::VEC_W-1:0]     eye_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            width_reg   <= crg_pkg::WIDTH_RESET;
            height_reg  <= crg_pkg::HEIGHT_RESET;
            extents_reg <= '0;
            basis_u_reg <= '0;
            basis_v_reg <= '0;
            forward_reg <= '0;
            eye_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                crg_pkg::REG_MODE:    mode_reg    <= cfg_data[0];
                crg_pkg::REG_WIDTH:   width_reg   <= cfg_data[crg_pkg::RES_W-1:0];
                crg_pkg::REG_HEIGHT:  height_reg  <= cfg_data[crg_pkg::RES_W-1:0];
                crg_pkg::REG_EXTENTS: extents_reg <= cfg_data[crg_pkg::EXT_W-1:0];
                crg_pkg::REG_BASIS_U: basis_u_reg <= cfg_data[crg_pkg::VEC_W-1:0];
                crg_pkg::REG_BASIS_V: basis_v_reg <= cfg_data[crg_pkg::VEC_W-1:0];
                crg_pkg::REG_FORWARD: forward_reg <= cfg_data[crg_pkg::VEC_W-1:0];
                crg_pkg::REG_EYE:     eye_reg     <= cfg_data[crg_pkg::VEC_W-1:0];
                default:              mode_reg    <= mode_reg;
            endcase
        end
    end

    function automatic logic [crg_pkg::DIM_W-1:0] clamp_res(input logic [crg_pkg::RES_W-1:0] n);
        if (n == '0)
            return crg_pkg::DIM_W'(1);
        if (n > crg_pkg::RES_W'(crg_pkg::MAX_RESOLUTION))
            return crg_pkg::DIM_W'(crg_pkg::MAX_RESOLUTION);
        return crg_pkg::DIM_W'(n);
    endfunction

    always_comb
    begin
        cfg.ortho   = mode_reg;
        cfg.width   = clamp_res(width_reg);
        cfg.height  = clamp_res(height_reg);
        cfg.ext_r   = crg_pkg::comp_t'(extents_reg[crg_pkg::EXT_W-1:crg_pkg::COMP_W]);
        cfg.ext_t   = crg_pkg::comp_t'(extents_reg[crg_pkg::COMP_W-1:0]);
        cfg.basis_u = basis_u_reg;
        cfg.basis_v = basis_v_reg;
        cfg.forward = forward_reg;
        cfg.eye     = eye_reg;
    end

endmodule

// File: sv/crg_offset.sv
`timescale 1ns / 1ps

// Lane 0 is the column offset against the width, lane 1 the row offset against the height.
module crg_offset (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [crg_pkg::PIX_W-1:0]     pixel_row,
    input  logic [crg_pkg::PIX_W-1:0]     pixel_column,
    input  crg_pkg::cam_cfg_t             cfg,
    output logic                          out_valid,
    output crg_pkg::div_in_t              lanes [2]
);

    logic                                 va_reg;
    logic                                 vb_reg;
    logic                                 vc_reg;
    logic [crg_pkg::PIX_W-1:0]            pix [2];
    logic [crg_pkg::DIM_W-1:0]            dim [2];
    crg_pkg::comp_t                       ext [2];
    logic signed [crg_pkg::T_W-1:0]       t_next [2];
    logic signed [crg_pkg::T_W-1:0]       t_reg [2];
    logic signed [crg_pkg::PROD_W-1:0]    prod_next [2];
    logic signed [crg_pkg::PROD_W-1:0]    prod_reg [2];
    logic [crg_pkg::MAG_W-1:0]            mag [2];
    crg_pkg::div_in_t                     lanes_next [2];
    crg_pkg::div_in_t                     lanes_reg [2];

    always_comb
    begin
        pix[0] = pixel_column;
        pix[1] = pixel_row;
        dim[0] = cfg.width;
        dim[1] = cfg.height;
        ext[0] = cfg.ext_r;
        ext[1] = cfg.ext_t;
        for (int l = 0; l < 2; l++)
        begin
            t_next[l]    = crg_pkg::T_W'({1'b0, pix[l], 1'b1}) - crg_pkg::T_W'(dim[l]);
            prod_next[l] = crg_pkg::PROD_W'(ext[l]) * crg_pkg::PROD_W'(t_reg[l]);
            mag[l]       = prod_reg[l][crg_pkg::PROD_W-1] ? crg_pkg::MAG_W'(-prod_reg[l])
                                                          : crg_pkg::MAG_W'(prod_reg[l]);
            lanes_next[l].neg = prod_reg[l][crg_pkg::PROD_W-1];
            lanes_next[l].num = {mag[l], 1'b0} + crg_pkg::NUM_W'(dim[l]);
            lanes_next[l].den = {dim[l], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            t_reg[l]     <= t_next[l];
            prod_reg[l]  <= prod_next[l];
            lanes_reg[l] <= lanes_next[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign lanes     = lanes_reg;

endmodule

// File: sv/crg_divider.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, a few quotient bits per stage, two lanes side by side.
module crg_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  crg_pkg::div_in_t                 lanes [2],
    output logic                             out_valid,
    output logic signed [crg_pkg::OFS_W-1:0] offset [2]
);

    localparam int STAGES = crg_pkg::DIV_STAGES;
    localparam int PAD_W  = crg_pkg::NUM_PAD_W;
    localparam int DEN_W  = crg_pkg::DEN_W;

    typedef struct packed {
        logic             neg;
        logic [PAD_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [PAD_W-1:0] quo;
    } lane_t;

    lane_t                            head [2];
    lane_t                            stage_next [STAGES][2];
    lane_t                            stage_reg [STAGES][2];
    logic [STAGES-1:0]                valid_reg;
    logic signed [crg_pkg::OFS_W-1:0] quo_s [2];
    logic signed [crg_pkg::OFS_W-1:0] offset_next [2];
    logic signed [crg_pkg::OFS_W-1:0] offset_reg [2];
    logic                             out_valid_reg;

    function automatic lane_t div_step(input lane_t s_in);
        lane_t            s;
        logic [DEN_W:0]   trial;
        s = s_in;
        for (int k = 0; k < crg_pkg::DIV_BPS; k++)
        begin
            trial = {s.rem, s.num[PAD_W-1]};
            s.num = {s.num[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, s.den})
            begin
                s.rem = DEN_W'(trial - {1'b0, s.den});
                s.quo = {s.quo[PAD_W-2:0], 1'b1};
            end
            else
            begin
                s.rem = trial[DEN_W-1:0];
                s.quo = {s.quo[PAD_W-2:0], 1'b0};
            end
        end
        return s;
    endfunction

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            head[l].neg = lanes[l].neg;
            head[l].num = PAD_W'(lanes[l].num);
            head[l].den = lanes[l].den;
            head[l].rem = '0;
            head[l].quo = '0;
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < 2; l++)
                    stage_next[s][l] = div_step(head[l]);
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int l = 0; l < 2; l++)
                    stage_next[s][l] = div_step(stage_reg[s-1][l]);
            end
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < 2; l++)
                stage_reg[s][l] <= stage_next[s][l];
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            quo_s[l]       = crg_pkg::OFS_W'(stage_reg[STAGES-1][l].quo);
            offset_next[l] = stage_reg[STAGES-1][l].neg ? -quo_s[l] : quo_s[l];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
            offset_reg[l] <= offset_next[l];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= STAGES'({valid_reg, in_valid});
            out_valid_reg <= valid_reg[STAGES-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign offset    = offset_reg;

endmodule

// File: sv/crg_combine.sv
`timescale 1ns / 1ps

module crg_combine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [crg_pkg::OFS_W-1:0] us,
    input  logic signed [crg_pkg::OFS_W-1:0] vs,
    input  crg_pkg::cam_cfg_t                cfg,
    output logic                             done,
    output logic signed [crg_pkg::OUT_W-1:0] origin [3],
    output logic signed [crg_pkg::OUT_W-1:0] direction [3]
);

    localparam int ACC_W = crg_pkg::ACC_W;
    localparam int P_W   = crg_pkg::PROD2_W;
    localparam int OUT_W = crg_pkg::OUT_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'({1'b0, {(OUT_W - 1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (crg_pkg::FRAC_BITS - 1);

    logic                      vp_reg;
    logic                      vs_reg;
    logic                      done_reg;
    logic signed [P_W-1:0]     pu_next [3];
    logic signed [P_W-1:0]     pv_next [3];
    logic signed [P_W-1:0]     pu_reg [3];
    logic signed [P_W-1:0]     pv_reg [3];
    crg_pkg::comp_t            base [3];
    logic signed [ACC_W-1:0]   acc_next [3];
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic signed [ACC_W-1:0]   sum [3];
    logic signed [ACC_W-1:0]   rnd [3];
    logic signed [OUT_W-1:0]   sat [3];
    logic signed [OUT_W-1:0]   pass [3];
    logic signed [OUT_W-1:0]   origin_next [3];
    logic signed [OUT_W-1:0]   direction_next [3];
    logic signed [OUT_W-1:0]   origin_reg [3];
    logic signed [OUT_W-1:0]   direction_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pu_next[i] = P_W'(us) * P_W'(crg_pkg::vec_comp(cfg.basis_u, i));
            pv_next[i] = P_W'(vs) * P_W'(crg_pkg::vec_comp(cfg.basis_v, i));

            base[i]     = cfg.ortho ? crg_pkg::vec_comp(cfg.eye, i)
                                    : crg_pkg::vec_comp(cfg.forward, i);
            acc_next[i] = (ACC_W'(base[i]) <<< crg_pkg::FRAC_BITS)
                        + ACC_W'(pu_reg[i]) + ACC_W'(pv_reg[i]);

            // Ties round away from zero: negative sums take one less before the shift.
            sum[i] = acc_reg[i] + HALF - ACC_W'(acc_reg[i][ACC_W-1]);
            rnd[i] = sum[i] >>> crg_pkg::FRAC_BITS;
            if (rnd[i] > SAT_HI)
                sat[i] = OUT_W'(SAT_HI);
            else if (rnd[i] < SAT_LO)
                sat[i] = OUT_W'(SAT_LO);
            else
                sat[i] = rnd[i][OUT_W-1:0];

            pass[i]           = cfg.ortho ? OUT_W'(crg_pkg::vec_comp(cfg.forward, i))
                                          : OUT_W'(crg_pkg::vec_comp(cfg.eye, i));
            origin_next[i]    = cfg.ortho ? sat[i] : pass[i];
            direction_next[i] = cfg.ortho ? pass[i] : sat[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pu_reg[i]        <= pu_next[i];
            pv_reg[i]        <= pv_next[i];
            acc_reg[i]       <= acc_next[i];
            origin_reg[i]    <= origin_next[i];
            direction_reg[i] <= direction_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg   <= 1'b0;
            vs_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vp_reg   <= in_valid;
            vs_reg   <= vp_reg;
            done_reg <= vs_reg;
        end
    end

    assign done      = done_reg;
    assign origin    = origin_reg;
    assign direction = direction_reg;

endmodule

// File: sv/camera_ray_generator.sv
`timescale 1ns / 1ps

// Pinhole camera primary ray generator.
// A pixel beat is taken on every rising edge where start is high and busy is low.
// The block never stalls its input, so busy stays low and one pixel may enter on
// every clock. Each pixel gives one ray: done is high for exactly one cycle while
// origin_x/y/z and direction_x/y/z hold the ray. The first offset stage loads on
// the edge that takes the start beat, and the ray then passes through the other
// register stages in line.
// The receiver cannot hold results off; rays leave in pixel order, one per cycle
// at most. The image plane offsets are formed by a divider that resolves four
// quotient bits per stage over nine stages and then registers its signed result,
// with three offset stages ahead of it and three multiply, sum and round stages
// behind it.
// Camera registers are written through cfg_write, cfg_index and cfg_data, one
// register per edge. They must be changed only while no pixel is in flight; the
// block itself does not enforce this. Reset clears the pipeline and loads
// perspective mode, a 640 by 480 image and zero vectors and extents.
module camera_ray_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [crg_pkg::PIX_W-1:0]             pixel_row,
    input  logic [crg_pkg::PIX_W-1:0]             pixel_column,
    input  logic                                  cfg_write,
    input  logic [crg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [crg_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  done,
    output logic signed [crg_pkg::OUT_W-1:0]      origin_x,
    output logic signed [crg_pkg::OUT_W-1:0]      origin_y,
    output logic signed [crg_pkg::OUT_W-1:0]      origin_z,
    output logic signed [crg_pkg::OUT_W-1:0]      direction_x,
    output logic signed [crg_pkg::OUT_W-1:0]      direction_y,
    output logic signed [crg_pkg::OUT_W-1:0]      direction_z
);

    crg_pkg::cam_cfg_t                 cfg;
    logic                              accept;
    logic                              ofs_valid;
    crg_pkg::div_in_t                  lanes [2];
    logic                              div_valid;
    logic signed [crg_pkg::OFS_W-1:0]  offset [2];
    logic signed [crg_pkg::OUT_W-1:0]  origin [3];
    logic signed [crg_pkg::OUT_W-1:0]  direction [3];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    crg_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crg_offset u_offset (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .cfg          (cfg),
        .out_valid    (ofs_valid),
        .lanes        (lanes)
    );

    crg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ofs_valid),
        .lanes     (lanes),
        .out_valid (div_valid),
        .offset    (offset)
    );

    crg_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .us        (offset[0]),
        .vs        (offset[1]),
        .cfg       (cfg),
        .done      (done),
        .origin    (origin),
        .direction (direction)
    );

    assign origin_x    = origin[0];
    assign origin_y    = origin[1];
    assign origin_z    = origin[2];
    assign direction_x = direction[0];
    assign direction_y = direction[1];
    assign direction_z = direction[2];

endmodule
